// ===== rtl/fcsg_pkg.sv =====
// fcsg_pkg: shared types and constants of the filled circle span generator.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package fcsg_pkg;

    localparam int CENTER_W = 14;
    localparam int COORD_W  = 15;
    localparam int RADIUS_W = 5;

    // One circle as it travels from the front stage to the span sequencer.
    typedef struct packed {
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic [RADIUS_W-1:0]        radius;   // already clamped to the bound
        logic                       point;    // radius zero: single pixel
    } circle_desc_t;

endpackage

// ===== rtl/fcsg_front.sv =====
// fcsg_front: input stage, takes circle transactions, clamps the radius and
// tags single-pixel circles. Depends on fcsg_pkg.
`timescale 1ns / 1ps

module fcsg_front #(
    parameter int MAX_RADIUS = 31
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [fcsg_pkg::CENTER_W-1:0]  center_x,
    input  logic signed [fcsg_pkg::CENTER_W-1:0]  center_y,
    input  logic [fcsg_pkg::RADIUS_W-1:0]         circle_radius,
    output logic                                  q_push,
    input  logic                                  q_full,
    output fcsg_pkg::circle_desc_t                q_data
);

    localparam logic [fcsg_pkg::RADIUS_W-1:0] MAX_R = (fcsg_pkg::RADIUS_W)'(MAX_RADIUS);

    logic                   valid_reg;
    fcsg_pkg::circle_desc_t desc_reg;
    logic                   accept;
    logic [fcsg_pkg::RADIUS_W-1:0] radius_sat;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign radius_sat = (circle_radius > MAX_R) ? MAX_R : circle_radius;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (!q_full)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (accept)
        begin
            desc_reg.cx     <= center_x;
            desc_reg.cy     <= center_y;
            desc_reg.radius <= radius_sat;
            desc_reg.point  <= (radius_sat == '0);
        end
    end

    assign q_push = valid_reg;
    assign q_data = desc_reg;

endmodule

// ===== rtl/fcsg_queue.sv =====
// fcsg_queue: two-entry queue of circle descriptors between front and back.
// Depends on fcsg_pkg.
`timescale 1ns / 1ps

module fcsg_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  fcsg_pkg::circle_desc_t data_in,
    input  logic                   pop,
    output logic                   empty,
    output fcsg_pkg::circle_desc_t data_out
);

    fcsg_pkg::circle_desc_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

// ===== rtl/fcsg_back.sv =====
// fcsg_back: span sequencer. Walks the rows of one circle, tracks the half
// width incrementally and drives the result register. Depends on fcsg_pkg.
`timescale 1ns / 1ps

module fcsg_back #(
    parameter int MAX_RADIUS = 31
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    output logic                                 q_pop,
    input  fcsg_pkg::circle_desc_t               q_data,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [fcsg_pkg::COORD_W-1:0]  row_y,
    output logic signed [fcsg_pkg::COORD_W-1:0]  span_left,
    output logic signed [fcsg_pkg::COORD_W-1:0]  span_right,
    output logic                                 last_span
);

    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int EW = $clog2(MAX_RADIUS * MAX_RADIUS + 1) + 1;
    localparam int CW = fcsg_pkg::COORD_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UP,
        ST_DOWN
    } state_t;

    state_t              state_reg;
    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic [RW-1:0]       r_reg;
    logic                point_reg;
    logic [RW-1:0]       a_reg;      // |dy| of the row being worked on
    logic [RW-1:0]       dx_reg;
    logic [EW-1:0]       e_reg;      // r*r - dy*dy - dx*dx, never negative
    logic [RW-1:0]       stash [MAX_RADIUS+1];
    logic                out_valid_reg;
    logic signed [CW-1:0] row_y_reg;
    logic signed [CW-1:0] left_reg;
    logic signed [CW-1:0] right_reg;
    logic                last_reg;

    logic                out_free;
    logic                step_up;
    logic [EW-1:0]       odd_dx;
    logic [EW-1:0]       odd_a;
    logic [RW-1:0]       dx_cur;
    logic signed [CW-1:0] dx_ext;
    logic signed [CW-1:0] a_ext;
    logic                emit;

    assign out_free = !out_valid_reg || pop;
    assign odd_dx   = EW'({dx_reg, 1'b1});                       // 2*dx + 1
    assign odd_a    = EW'({RW'(a_reg - 1'b1), 1'b1});            // 2*a - 1
    assign step_up  = (state_reg == ST_UP) && (e_reg >= odd_dx);
    assign dx_cur   = (state_reg == ST_DOWN) ? stash[a_reg] : dx_reg;
    assign dx_ext   = CW'(signed'({1'b0, dx_cur}));
    assign a_ext    = CW'(signed'({1'b0, a_reg}));
    assign emit     = out_free && !step_up
                      && ((state_reg == ST_UP) || (state_reg == ST_DOWN));

    assign q_pop = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            r_reg         <= '0;
            point_reg     <= 1'b0;
            a_reg         <= '0;
            dx_reg        <= '0;
            e_reg         <= '0;
            row_y_reg     <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                row_y_reg     <= (state_reg == ST_UP) ? cy_reg - a_ext : cy_reg + a_ext;
                left_reg      <= cx_reg - dx_ext;
                right_reg     <= cx_reg + dx_ext;
                last_reg      <= (state_reg == ST_UP) ? (point_reg && (a_reg == '0))
                                                      : (a_reg == r_reg);
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cx_reg    <= CW'(q_data.cx);
                        cy_reg    <= CW'(q_data.cy);
                        r_reg     <= RW'(q_data.radius);
                        point_reg <= q_data.point;
                        a_reg     <= RW'(q_data.radius);
                        dx_reg    <= '0;
                        e_reg     <= '0;
                        state_reg <= ST_UP;
                    end
                end
                ST_UP:
                begin
                    if (step_up)
                    begin
                        dx_reg <= dx_reg + 1'b1;
                        e_reg  <= e_reg - odd_dx;
                    end
                    else if (out_free)
                    begin
                        if (a_reg == '0)
                        begin
                            if (point_reg)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                a_reg     <= RW'(1);
                                state_reg <= ST_DOWN;
                            end
                        end
                        else
                        begin
                            a_reg <= a_reg - 1'b1;
                            e_reg <= e_reg + odd_a;
                        end
                    end
                end
                ST_DOWN:
                begin
                    if (out_free)
                    begin
                        if (a_reg == r_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            a_reg <= a_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Half widths of the upper half, replayed in mirror order for the lower half.
    always_ff @(posedge clk) begin
        if (emit && (state_reg == ST_UP))
        begin
            stash[a_reg] <= dx_reg;
        end
    end

    assign empty      = !out_valid_reg;
    assign row_y      = row_y_reg;
    assign span_left  = left_reg;
    assign span_right = right_reg;
    assign last_span  = last_reg;

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (a_reg <= r_reg))
        else $error("row offset beyond radius");

    a_down_not_point: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DOWN) |-> ((a_reg != '0) && !point_reg))
        else $error("lower half entered with bad offset");

    a_dx_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP) |-> (dx_reg <= r_reg))
        else $error("half width exceeds radius");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (state_reg == ST_DOWN) && (a_reg == r_reg)) |=> (state_reg == ST_IDLE))
        else $error("sequencer kept running after last span");

endmodule

// ===== rtl/filled_circle_span_generator_top.sv =====
// filled_circle_span_generator_top: top level, front stage, descriptor queue
// and span sequencer. Depends on fcsg_pkg, fcsg_front, fcsg_queue, fcsg_back.
`timescale 1ns / 1ps

// Usage
//   Input channel (push/full): one transaction is one circle, center_x,
//   center_y (14-bit signed) and circle_radius (5-bit). A radius above
//   MAX_RADIUS is clamped to MAX_RADIUS.
//   Result channel (empty/pop): one transaction is one horizontal span,
//   row_y, span_left, span_right (15-bit signed, inclusive ends) and
//   last_span. A circle of radius r gives 2r+1 spans, top row first;
//   last_span marks its bottom row. Radius 0 gives one single-pixel span.
// Timing
//   The front stage registers a circle and hands it to a two-entry queue,
//   so up to three circles can be taken while one is being drawn.
//   The sequencer tracks the half width incrementally: in the upper half
//   each step either widens the half width by one (r in total) or emits a
//   row; the lower half replays stored widths at one row per cycle while
//   the receiver keeps the result register free.
// Reset and stalls
//   Reset empties the queue and result register; nothing needs clearing.
//   While the receiver holds pop low the result register holds its span,
//   the sequencer waits, and full rises once the queue and front fill.

module filled_circle_span_generator_top #(
    parameter int MAX_RADIUS = 31
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [fcsg_pkg::CENTER_W-1:0] center_x,
    input  logic signed [fcsg_pkg::CENTER_W-1:0] center_y,
    input  logic [fcsg_pkg::RADIUS_W-1:0]        circle_radius,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [fcsg_pkg::COORD_W-1:0]  row_y,
    output logic signed [fcsg_pkg::COORD_W-1:0]  span_left,
    output logic signed [fcsg_pkg::COORD_W-1:0]  span_right,
    output logic                                 last_span
);

    // front -> queue
    logic                   fq_push;
    logic                   fq_full;
    fcsg_pkg::circle_desc_t fq_data;
    // queue -> back
    logic                   qb_pop;
    logic                   qb_empty;
    fcsg_pkg::circle_desc_t qb_data;

    fcsg_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .center_x      (center_x),
        .center_y      (center_y),
        .circle_radius (circle_radius),
        .q_push        (fq_push),
        .q_full        (fq_full),
        .q_data        (fq_data)
    );

    fcsg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fq_push),
        .full     (fq_full),
        .data_in  (fq_data),
        .pop      (qb_pop),
        .empty    (qb_empty),
        .data_out (qb_data)
    );

    fcsg_back #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (qb_empty),
        .q_pop      (qb_pop),
        .q_data     (qb_data),
        .empty      (empty),
        .pop        (pop),
        .row_y      (row_y),
        .span_left  (span_left),
        .span_right (span_right),
        .last_span  (last_span)
    );

endmodule

// ===== tb/filled_circle_span_generator_top_tb.sv =====
// filled_circle_span_generator_top_tb: self-checking testbench for the filled circle span generator.
// Depends on fcsg_pkg and filled_circle_span_generator_top and, through the top, on its submodules.
`timescale 1ns / 1ps

module filled_circle_span_generator_top_tb;

    localparam int CENTER_W = fcsg_pkg::CENTER_W;
    localparam int COORD_W  = fcsg_pkg::COORD_W;
    localparam int RADIUS_W = fcsg_pkg::RADIUS_W;

    localparam int MAX_RADIUS  = 31;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS  = 40;
    localparam int PHASE_COUNT  = 8;

    // Traffic shape of a stretch of the run: who idles, and how often.
    typedef enum {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH_LIGHT
    } pace_t;

    // One circle waiting to be driven.
    typedef struct {
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic [RADIUS_W-1:0]        radius;
        pace_t                      pace;
        bit                         drain_first;   // hold off until no span is outstanding
    } circle_item_t;

    // One horizontal span as the block should deliver it.
    typedef struct {
        logic signed [COORD_W-1:0] row_y;
        logic signed [COORD_W-1:0] span_left;
        logic signed [COORD_W-1:0] span_right;
        logic                      last_span;
    } span_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic signed [CENTER_W-1:0] center_x = '0;
    logic signed [CENTER_W-1:0] center_y = '0;
    logic [RADIUS_W-1:0]        circle_radius = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic signed [COORD_W-1:0]  row_y;
    logic signed [COORD_W-1:0]  span_left;
    logic signed [COORD_W-1:0]  span_right;
    logic                       last_span;

    circle_item_t pending_circles[$];
    span_t        expected_spans[$];
    circle_item_t next_circle;
    span_t        oldest_span;
    pace_t        active_pace = PACE_FULL;
    bit           push_taken = 1'b0;
    int           mismatch_count = 0;
    int           cycle_count = 0;

    filled_circle_span_generator_top #(
        .MAX_RADIUS(MAX_RADIUS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .center_x(center_x),
        .center_y(center_y),
        .circle_radius(circle_radius),
        .empty(empty),
        .pop(pop),
        .row_y(row_y),
        .span_left(span_left),
        .span_right(span_right),
        .last_span(last_span)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Span predictor: every row offset from -r to +r, top row first. The
    // half width is the floor square root of r^2 - dy^2; the bottom row
    // closes the circle. Radius above the bound is clamped.
    // ------------------------------------------------------------------
    task automatic predict_circle_spans(input logic signed [CENTER_W-1:0] cx,
                                        input logic signed [CENTER_W-1:0] cy,
                                        input logic [RADIUS_W-1:0] radius);
        int    r;
        int    dy;
        int    ady;
        int    half_width;
        int    x0;
        int    y0;
        span_t s;
        r  = int'(radius);
        x0 = int'(cx);
        y0 = int'(cy);
        if (r > MAX_RADIUS)
            r = MAX_RADIUS;
        for (dy = -r; dy <= r; dy++)
        begin
            ady = (dy < 0) ? -dy : dy;
            half_width = 0;
            while ((half_width + 1) * (half_width + 1) <= r * r - ady * ady)
                half_width++;
            s.row_y      = COORD_W'(y0 + dy);
            s.span_left  = COORD_W'(x0 - half_width);
            s.span_right = COORD_W'(x0 + half_width);
            s.last_span  = (dy == r);
            expected_spans.insert(expected_spans.size(), s);
        end
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic queue_circle(input int cx, input int cy, input int radius,
                                input pace_t pace, input bit drain_first);
        circle_item_t c;
        c.cx          = CENTER_W'(cx);
        c.cy          = CENTER_W'(cy);
        c.radius      = RADIUS_W'(radius);
        c.pace        = pace;
        c.drain_first = drain_first;
        pending_circles.insert(pending_circles.size(), c);
    endtask

    // Centres lean toward both ends of the range; the rest spread over all bits.
    function automatic int random_center();
        case ($urandom_range(0, 3))
            0:       return -8192 + int'($urandom_range(0, 15));
            1:       return 8191 - int'($urandom_range(0, 15));
            default: return int'($urandom_range(0, 2 ** CENTER_W - 1));
        endcase
    endfunction

    // Mostly full range radii, with extra weight on tiny and maximal circles.
    function automatic int random_radius();
        case ($urandom_range(0, 4))
            0:       return int'($urandom_range(0, 3));
            1:       return int'($urandom_range(MAX_RADIUS - 3, MAX_RADIUS));
            default: return int'($urandom_range(0, 2 ** RADIUS_W - 1));
        endcase
    endfunction

    function automatic int send_idle_pct(input pace_t pace);
        case (pace)
            PACE_SEND_IDLE:  return 68;
            PACE_BOTH_LIGHT: return 7;
            default:         return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input pace_t pace);
        case (pace)
            PACE_RECV_STALL: return 68;
            PACE_BOTH_LIGHT: return 7;
            default:         return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Circle driver (falling edge). push stays high with stable fields
    // until the transaction is taken; a new circle is only offered once
    // the previous one went through.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!push || push_taken))
        begin
            push_taken = 1'b0;
            if (pending_circles.size() == 0)
            begin
                push <= 1'b0;
            end
            else if (pending_circles[0].drain_first && expected_spans.size() != 0)
            begin
                push <= 1'b0;
            end
            else if ($urandom_range(0, 99) < send_idle_pct(pending_circles[0].pace))
            begin
                push <= 1'b0;
            end
            else
            begin
                next_circle   = pending_circles.pop_front();
                active_pace   = next_circle.pace;
                center_x      <= next_circle.cx;
                center_y      <= next_circle.cy;
                circle_radius <= next_circle.radius;
                push          <= 1'b1;
            end
        end
    end

    // Span receiver back-pressure (falling edge), following the current pace.
    always @(negedge clk)
    begin
        if (rst_n)
            pop <= ($urandom_range(0, 99) >= recv_stall_pct(active_pace));
    end

    // ------------------------------------------------------------------
    // Monitor (rising edge): predicts spans for each accepted circle and
    // checks each accepted span against the oldest expectation. Prediction
    // comes first so a span taken on the same edge still finds its entry.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (push && !full)
            begin
                predict_circle_spans(center_x, center_y, circle_radius);
                push_taken = 1'b1;
            end
            if (pop && !empty)
            begin
                if (expected_spans.size() == 0)
                begin
                    $display("%0t: unexpected span, expected none, actual row %0d left %0d right %0d last %0d",
                             $time, row_y, span_left, span_right, last_span);
                    mismatch_count++;
                end
                else
                begin
                    oldest_span = expected_spans.pop_front();
                    check_field("row_y", oldest_span.row_y, row_y);
                    check_field("span_left", oldest_span.span_left, span_left);
                    check_field("span_right", oldest_span.span_right, span_right);
                    check_field("last_span", oldest_span.last_span, last_span);
                end
            end
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("%0t: timeout after %0d cycles, %0d spans outstanding",
                         $time, cycle_count, expected_spans.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        // Directed: coordinate extremes, radius 0/1/max, back-to-back large
        // circles to fill the queue, and runs of single-pixel circles.
        queue_circle(0, 0, 0, PACE_FULL, 1'b0);
        queue_circle(0, 0, 1, PACE_FULL, 1'b0);
        queue_circle(0, 0, 2, PACE_FULL, 1'b0);
        queue_circle(-8192, -8192, MAX_RADIUS, PACE_FULL, 1'b0);
        queue_circle(8191, 8191, MAX_RADIUS, PACE_FULL, 1'b0);
        queue_circle(-8192, 8191, MAX_RADIUS, PACE_FULL, 1'b0);
        queue_circle(8191, -8192, MAX_RADIUS, PACE_FULL, 1'b0);
        queue_circle(8191, -8192, 0, PACE_FULL, 1'b0);
        queue_circle(-8192, -8192, 0, PACE_FULL, 1'b0);
        queue_circle(8191, 8191, 0, PACE_FULL, 1'b0);
        queue_circle(-8192, 8191, 1, PACE_FULL, 1'b0);
        queue_circle(0, 0, MAX_RADIUS, PACE_FULL, 1'b0);
        queue_circle(-1, -1, 5, PACE_FULL, 1'b0);
        queue_circle(1, 1, 30, PACE_FULL, 1'b0);
        queue_circle(100, -100, 3, PACE_FULL, 1'b0);
        queue_circle(-8192, 0, 16, PACE_FULL, 1'b0);
        queue_circle(0, 8191, 7, PACE_FULL, 1'b0);
        queue_circle(-5461, 5461, 0, PACE_FULL, 1'b0);
        queue_circle(5461, -5462, 0, PACE_FULL, 1'b0);
        queue_circle(2730, -2731, 0, PACE_FULL, 1'b0);
        queue_circle(-2731, 2730, 0, PACE_FULL, 1'b0);

        // Random phases cycle through the four paces; each phase starts
        // only once the block has fully drained.
        for (int p = 0; p < PHASE_COUNT; p++)
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_circle(random_center(), random_center(), random_radius(),
                             pace_t'(p % 4), i == 0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_circles.size() != 0 || push)
            @(posedge clk);
        while (expected_spans.size() != 0)
            @(posedge clk);
        // Any span arriving now is extra and gets flagged by the monitor.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
